@@ design/rcf_pkg.sv @@
// Shared types and constants for the RGB crossfade flash sequencer.
// Used by the register file, controller, datapath and top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcf_pkg;

	localparam int MAX_RAMP_STEPS_DEF = 500;

	localparam int CHAN_W    = 8;
	localparam int COLOR_W   = 24;
	localparam int BRIGHT_W  = 8;
	localparam int FLASH_W   = 7;
	localparam int STEP_W    = 9;
	localparam int HALF_W    = 8;
	localparam int NUM_LANES = 3;

	// Dividend width of the lerp division: channel difference times ramp position.
	localparam int NUM_W     = CHAN_W + STEP_W;
	localparam int MOD_STEPS = STEP_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W     = $clog2(NUM_W);

	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	typedef enum logic [2:0] {
		REG_START_COLOR = 3'd0,
		REG_END_COLOR   = 3'd1,
		REG_BRIGHTNESS  = 3'd2,
		REG_FLASH_COUNT = 3'd3,
		REG_STEPS       = 3'd4,
		REG_INFINITE    = 3'd5,
		REG_NEXT_MODE   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [COLOR_W-1:0]  start_color;
		logic [COLOR_W-1:0]  end_color;
		logic [BRIGHT_W-1:0] brightness;
		logic [FLASH_W-1:0]  flash_count;
		logic [STEP_W-1:0]   crossfade_steps;
		logic                infinite;
		logic                has_next_mode;
	} cfg_t;

	typedef struct packed {
		logic ld_mod;
		logic div_step;
		logic upd;
		logic ld_lerp;
		logic ld_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ design/rcf_regs.sv @@
// Configuration register file with an APB-style slave port.
// Depends on rcf_pkg; also flags the state clear caused by a change of the infinite flag.
`timescale 1ns / 1ps
`default_nettype none

module rcf_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rcf_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rcf_pkg::DATA_W-1:0] pwdata,
	output logic      [rcf_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output rcf_pkg::cfg_t                   cfg,
	output logic                            clr_state
);
	import rcf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	assign clr_state = wr_en && (idx == REG_INFINITE) && (pwdata[0] != cfg_q.infinite);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_color     <= '0;
			cfg_q.end_color       <= '0;
			cfg_q.brightness      <= '1;
			cfg_q.flash_count     <= FLASH_W'(1);
			cfg_q.crossfade_steps <= STEP_W'(1);
			cfg_q.infinite        <= 1'b0;
			cfg_q.has_next_mode   <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_START_COLOR: cfg_q.start_color     <= pwdata[COLOR_W-1:0];
				REG_END_COLOR:   cfg_q.end_color       <= pwdata[COLOR_W-1:0];
				REG_BRIGHTNESS:  cfg_q.brightness      <= pwdata[BRIGHT_W-1:0];
				REG_FLASH_COUNT: cfg_q.flash_count     <= pwdata[FLASH_W-1:0];
				REG_STEPS:       cfg_q.crossfade_steps <= pwdata[STEP_W-1:0];
				REG_INFINITE:    cfg_q.infinite        <= pwdata[0];
				REG_NEXT_MODE:   cfg_q.has_next_mode   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_START_COLOR: prdata = DATA_W'(cfg_q.start_color);
			REG_END_COLOR:   prdata = DATA_W'(cfg_q.end_color);
			REG_BRIGHTNESS:  prdata = DATA_W'(cfg_q.brightness);
			REG_FLASH_COUNT: prdata = DATA_W'(cfg_q.flash_count);
			REG_STEPS:       prdata = DATA_W'(cfg_q.crossfade_steps);
			REG_INFINITE:    prdata = DATA_W'(cfg_q.infinite);
			REG_NEXT_MODE:   prdata = DATA_W'(cfg_q.has_next_mode);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ design/rcf_ctrl.sv @@
// Controller state machine that sequences one tick through modulo, update, divide and output.
// Depends on rcf_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module rcf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output rcf_pkg::dp_cmd_t   cmd,
	input  wire rcf_pkg::dp_stat_t stat
);
	import rcf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_UPD,
		S_LOAD,
		S_DIV,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	assign cmd.ld_mod   = accept;
	assign cmd.div_step = (state_q == S_MOD) || (state_q == S_DIV);
	assign cmd.upd      = (state_q == S_UPD);
	assign cmd.ld_lerp  = (state_q == S_LOAD);
	assign cmd.ld_out   = (state_q == S_FIN) && !stat.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MOD;
						cnt_q   <= CNT_W'(MOD_STEPS - 1);
					end
				end
				S_MOD: begin
					if (cnt_q == '0) begin
						state_q <= S_UPD;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_UPD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIV;
					cnt_q   <= CNT_W'(DIV_STEPS - 1);
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_FIN: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	a_out_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |=> state_q == S_IDLE)
		else $error("controller did not return to idle after loading a result");

	a_mod_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && cnt_q == '0) |=> state_q == S_UPD)
		else $error("modulo pass did not end after its last step");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ld_mod, cmd.upd, cmd.ld_lerp, cmd.ld_out}))
		else $error("more than one load command in a cycle");

endmodule

`default_nettype wire

@@ design/rcf_dp.sv @@
// Datapath: phase and half-flash state, three-lane restoring divider and output register.
// Depends on rcf_pkg; lane 0 of the divider also reduces the phase modulo the step count.
`timescale 1ns / 1ps
`default_nettype none

module rcf_dp #(
	parameter int MAX_RAMP_STEPS = rcf_pkg::MAX_RAMP_STEPS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rcf_pkg::cfg_t              cfg,
	input  wire logic                       clr_state,
	input  wire logic                       restart,
	input  wire rcf_pkg::dp_cmd_t           cmd,
	output rcf_pkg::dp_stat_t               stat,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            color_valid,
	output logic      [rcf_pkg::CHAN_W-1:0] red,
	output logic      [rcf_pkg::CHAN_W-1:0] green,
	output logic      [rcf_pkg::CHAN_W-1:0] blue,
	output logic                            switch_mode
);
	import rcf_pkg::*;

	localparam int StepsMaxI = (1 << STEP_W) - 1;
	localparam int StepsCapI = (MAX_RAMP_STEPS < StepsMaxI) ? MAX_RAMP_STEPS : StepsMaxI;
	localparam logic [STEP_W-1:0] StepsCap = STEP_W'(StepsCapI);

	logic [STEP_W-1:0] phase_q;
	logic [HALF_W-1:0] hf_q;
	logic              restart_q;
	logic [STEP_W-1:0] dvs_q;
	logic [STEP_W-1:0] p_q;
	logic              out_valid_q;
	logic              color_q;
	logic              switch_q;
	logic [CHAN_W-1:0] red_q;
	logic [CHAN_W-1:0] green_q;
	logic [CHAN_W-1:0] blue_q;

	logic [NUM_W-1:0]  num_q [NUM_LANES];
	logic [STEP_W-1:0] rem_q [NUM_LANES];
	logic [NUM_W-1:0]  quo_q [NUM_LANES];
	logic              neg_q [NUM_LANES];

	logic [STEP_W-1:0] steps_eff;
	logic [STEP_W-1:0] steps_m1;
	logic [STEP_W-1:0] phase_src;
	logic [STEP_W:0]   p_plus;
	logic [STEP_W-1:0] phase_nxt;
	logic [HALF_W-1:0] hf_nxt;
	logic [STEP_W-1:0] k_val;
	logic              running;
	logic              valid_c;
	logic              switch_c;

	logic [STEP_W:0]   trial    [NUM_LANES];
	logic [STEP_W:0]   sub      [NUM_LANES];
	logic              ge       [NUM_LANES];
	logic [STEP_W-1:0] rem_n    [NUM_LANES];
	logic [CHAN_W-1:0] s_ch     [NUM_LANES];
	logic [CHAN_W-1:0] e_ch     [NUM_LANES];
	logic              neg      [NUM_LANES];
	logic [CHAN_W-1:0] dif      [NUM_LANES];
	logic [NUM_W-1:0]  prod     [NUM_LANES];
	logic [NUM_W-1:0]  lerp_num [NUM_LANES];
	logic [CHAN_W-1:0] chan     [NUM_LANES];

	always_comb begin
		steps_eff = cfg.crossfade_steps;
		if (steps_eff == '0) begin
			steps_eff = STEP_W'(1);
		end
		if (steps_eff > StepsCap) begin
			steps_eff = StepsCap;
		end
	end

	assign steps_m1  = steps_eff - STEP_W'(1);
	assign phase_src = restart ? '0 : phase_q;

	assign p_plus    = {1'b0, rem_q[0]} + (STEP_W + 1)'(1);
	assign phase_nxt = (p_plus >= {1'b0, steps_eff}) ? '0 : p_plus[STEP_W-1:0];

	always_comb begin
		hf_nxt = hf_q;
		if (!restart_q && rem_q[0] == '0) begin
			if (cfg.infinite) begin
				hf_nxt = hf_q + HALF_W'(1);
			end else if (hf_q != '1) begin
				hf_nxt = hf_q + HALF_W'(1);
			end
		end
	end

	assign k_val    = hf_q[0] ? (steps_m1 - p_q) : p_q;
	assign running  = (hf_q[HALF_W-1:1] < cfg.flash_count) || cfg.infinite;
	assign valid_c  = running && (cfg.brightness != '0);
	assign switch_c = !running && cfg.has_next_mode;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			trial[i] = {rem_q[i], num_q[i][NUM_W-1]};
			sub[i]   = trial[i] - {1'b0, dvs_q};
			ge[i]    = (trial[i] >= {1'b0, dvs_q});
			rem_n[i] = ge[i] ? sub[i][STEP_W-1:0] : trial[i][STEP_W-1:0];

			s_ch[i] = cfg.start_color[CHAN_W*(NUM_LANES-1-i) +: CHAN_W];
			e_ch[i] = cfg.end_color[CHAN_W*(NUM_LANES-1-i) +: CHAN_W];
			neg[i]  = (e_ch[i] < s_ch[i]);
			dif[i]  = neg[i] ? (s_ch[i] - e_ch[i]) : (e_ch[i] - s_ch[i]);
			prod[i] = NUM_W'(dif[i]) * NUM_W'(k_val);
			// A falling channel rounds the quotient up, which floors the negative step.
			lerp_num[i] = neg[i] ? (prod[i] + NUM_W'(steps_m1) - NUM_W'(1)) : prod[i];

			if (dvs_q == '0) begin
				chan[i] = s_ch[i];
			end else if (neg_q[i]) begin
				chan[i] = s_ch[i] - quo_q[i][CHAN_W-1:0];
			end else begin
				chan[i] = s_ch[i] + quo_q[i][CHAN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			hf_q        <= '0;
			restart_q   <= 1'b0;
			dvs_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_state) begin
				phase_q <= '0;
				hf_q    <= '0;
			end else if (cmd.ld_mod && restart) begin
				phase_q <= '0;
				hf_q    <= '0;
			end else if (cmd.upd) begin
				phase_q <= phase_nxt;
				hf_q    <= hf_nxt;
			end

			if (cmd.ld_mod) begin
				restart_q <= restart;
				dvs_q     <= steps_eff;
			end else if (cmd.ld_lerp) begin
				dvs_q <= steps_m1;
			end

			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_LANES; i++) begin
			if (cmd.ld_mod) begin
				num_q[i] <= (i == 0) ? {phase_src, {(NUM_W - STEP_W){1'b0}}} : '0;
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end else if (cmd.ld_lerp) begin
				num_q[i] <= lerp_num[i];
				rem_q[i] <= '0;
				quo_q[i] <= '0;
				neg_q[i] <= neg[i];
			end else if (cmd.div_step) begin
				num_q[i] <= {num_q[i][NUM_W-2:0], 1'b0};
				rem_q[i] <= rem_n[i];
				quo_q[i] <= {quo_q[i][NUM_W-2:0], ge[i]};
			end
		end

		if (cmd.upd) begin
			p_q <= rem_q[0];
		end

		if (cmd.ld_out) begin
			color_q  <= valid_c;
			switch_q <= switch_c;
			red_q    <= valid_c ? chan[0] : '0;
			green_q  <= valid_c ? chan[1] : '0;
			blue_q   <= valid_c ? chan[2] : '0;
		end
	end

	assign stat.out_busy = out_valid_q && out_stall;
	assign out_valid     = out_valid_q;
	assign color_valid   = color_q;
	assign switch_mode   = switch_q;
	assign red           = red_q;
	assign green         = green_q;
	assign blue          = blue_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dvs_q != '0) |-> (rem_q[0] < dvs_q) && (rem_q[1] < dvs_q) && (rem_q[2] < dvs_q))
		else $error("divider remainder reached the divisor");

	a_dark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !color_q) |-> (red_q == '0) && (green_q == '0) && (blue_q == '0))
		else $error("colour channels not zero without a driven colour");

	a_color_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && color_q) |-> !switch_q)
		else $error("mode switch requested while a colour is driven");

endmodule

`default_nettype wire

@@ design/rgb_crossfade_flash_sequencer.sv @@
// Top level of the RGB crossfade flash sequencer.
// Instantiates rcf_regs, rcf_ctrl and rcf_dp; depends on rcf_pkg.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   restart
//   output    out_valid / out_stall color_valid, red, green, blue, switch_mode
//   config    APB psel / penable    paddr, pwdata, prdata (pready always high)
//
// Each transaction runs through the shared restoring divider twice:
// its steps first reduce the phase, then interpolate the three channels.
// One transaction is processed at a time; a finished result waits in the output register.
// When the output is stalled with a result pending, the controller holds in its final state.
// Reset is asynchronous and active low and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rgb_crossfade_flash_sequencer #(
	parameter int MAX_RAMP_STEPS = rcf_pkg::MAX_RAMP_STEPS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       restart,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            color_valid,
	output logic      [rcf_pkg::CHAN_W-1:0] red,
	output logic      [rcf_pkg::CHAN_W-1:0] green,
	output logic      [rcf_pkg::CHAN_W-1:0] blue,
	output logic                            switch_mode,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rcf_pkg::ADDR_W-1:0] paddr,
	input  wire logic [rcf_pkg::DATA_W-1:0] pwdata,
	output logic      [rcf_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import rcf_pkg::*;

	cfg_t     cfg;
	logic     clr_state;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	rcf_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg),
		.clr_state (clr_state)
	);

	rcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	rcf_dp #(
		.MAX_RAMP_STEPS (MAX_RAMP_STEPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.clr_state   (clr_state),
		.restart     (restart),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.color_valid (color_valid),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.switch_mode (switch_mode)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rgb_crossfade_flash_sequencer: animation ticks drive the block
// and each colour result is checked against a cycle-free crossfade predictor in a scoreboard.
// Depends on rcf_pkg and the rgb_crossfade_flash_sequencer RTL only.

module tb;
	import rcf_pkg::*;

	localparam int UNMAPPED_REG  = 7;
	localparam int RAND_TICKS    = 1600;
	localparam int QUIET_TICKS   = 150;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic              color_valid;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              switch_mode;
	} pixel_t;

	class flash_scoreboard;
		bit [COLOR_W-1:0]  start_color;
		bit [COLOR_W-1:0]  end_color;
		bit [BRIGHT_W-1:0] brightness;
		bit [FLASH_W-1:0]  flash_count;
		bit [STEP_W-1:0]   crossfade_steps;
		bit                infinite;
		bit                has_next_mode;
		int unsigned       ramp_pos;
		int unsigned       half_flashes;
		pixel_t            pending_pixels[$];
		int                errors;

		function new();
			start_color     = '0;
			end_color       = '0;
			brightness      = 8'd255;
			flash_count     = 7'd1;
			crossfade_steps = 9'd1;
			infinite        = 1'b0;
			has_next_mode   = 1'b0;
			ramp_pos        = 0;
			half_flashes    = 0;
			errors          = 0;
		endfunction

		function void note_config(int idx, bit [DATA_W-1:0] value);
			case (idx)
			REG_START_COLOR: start_color = value[COLOR_W-1:0];
			REG_END_COLOR: end_color = value[COLOR_W-1:0];
			REG_BRIGHTNESS: brightness = value[BRIGHT_W-1:0];
			REG_FLASH_COUNT: flash_count = value[FLASH_W-1:0];
			REG_STEPS: crossfade_steps = value[STEP_W-1:0];
			REG_INFINITE: begin
				if (value[0] != infinite) begin
					infinite     = value[0];
					ramp_pos     = 0;
					half_flashes = 0;
				end
			end
			REG_NEXT_MODE: has_next_mode = value[0];
			default: ;
			endcase
		endfunction

		// Floor of start + diff * k / d, also when the difference is negative.
		function logic [CHAN_W-1:0] blend(int unsigned s, int unsigned e, int unsigned k,
				int unsigned d);
			if (d == 0)
				return s[CHAN_W-1:0];
			if (e >= s)
				return CHAN_W'(s + (e - s) * k / d);
			return CHAN_W'(s - ((s - e) * k + d - 1) / d);
		endfunction

		function void note_input(bit restart_tick);
			int unsigned steps;
			int unsigned pos;
			int unsigned k;
			int unsigned d;
			bit          active;
			pixel_t      px;
			steps = crossfade_steps;
			if (steps == 0)
				steps = 1;
			if (steps > MAX_RAMP_STEPS_DEF)
				steps = MAX_RAMP_STEPS_DEF;
			if (restart_tick) begin
				ramp_pos     = 0;
				half_flashes = 0;
			end
			pos = ramp_pos % steps;
			if (!restart_tick && pos == 0) begin
				if (infinite)
					half_flashes = (half_flashes + 1) % 256;
				else if (half_flashes < 255)
					half_flashes++;
			end
			active = (half_flashes / 2 < flash_count) || infinite;
			px = '{default: '0};
			if (active && brightness != 0) begin
				d = steps - 1;
				k = half_flashes[0] ? d - pos : pos;
				px.color_valid = 1'b1;
				px.red   = blend(start_color[23:16], end_color[23:16], k, d);
				px.green = blend(start_color[15:8], end_color[15:8], k, d);
				px.blue  = blend(start_color[7:0], end_color[7:0], k, d);
			end else if (half_flashes / 2 >= flash_count && !infinite && has_next_mode) begin
				px.switch_mode = 1'b1;
			end
			ramp_pos = (pos + 1 >= steps) ? 0 : pos + 1;
			pending_pixels.push_back(px);
		endfunction

		function void compare(string field, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(pixel_t got);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected transaction, color_valid %0d rgb %0d %0d %0d switch %0d",
					$time, got.color_valid, got.red, got.green, got.blue, got.switch_mode);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			compare("color_valid", want.color_valid, got.color_valid);
			compare("red", want.red, got.red);
			compare("green", want.green, got.green);
			compare("blue", want.blue, got.blue);
			compare("switch_mode", want.switch_mode, got.switch_mode);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              restart = 1'b0;
	logic              out_stall = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic              in_stall;
	logic              out_valid;
	logic              color_valid;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              switch_mode;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	flash_scoreboard sb;
	bit              quiet = 1'b0;
	int              gap_pct = 20;

	rgb_crossfade_flash_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.color_valid(color_valid),
		.red(red),
		.green(green),
		.blue(blue),
		.switch_mode(switch_mode),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("rgb_crossfade_flash_sequencer test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(pixel_t'{color_valid, red, green, blue, switch_mode});
	end

	initial begin
		int n;
		int pick;
		bit hold;
		forever begin
			pick = $urandom_range(99);
			hold = !quiet && pick < 35;
			n = (!quiet && pick >= 90) ? $urandom_range(50, 300) : $urandom_range(1, 18);
			repeat (n) begin
				@(negedge clk);
				out_stall <= hold;
			end
		end
	end

	task automatic pause_input(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
			restart  <= 1'($urandom);
		end
	endtask

	task automatic send_tick(bit restart_tick);
		if (!quiet && $urandom_range(99) < gap_pct)
			pause_input($urandom_range(1, 18));
		@(negedge clk);
		in_valid <= 1'b1;
		restart  <= restart_tick;
		do @(posedge clk); while (in_stall);
		sb.note_input(restart_tick);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic reg_write(int idx, bit [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.note_config(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic bit [CHAN_W-1:0] pick_chan();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return '0;
		if (r < 40)
			return '1;
		return CHAN_W'($urandom);
	endfunction

	function automatic bit [DATA_W-1:0] pick_color();
		return {8'd0, pick_chan(), pick_chan(), pick_chan()};
	endfunction

	task automatic shuffle_setup(bit marathon);
		int r;
		if (marathon) begin
			reg_write(REG_STEPS, $urandom_range(0, 1));
			reg_write(REG_BRIGHTNESS, $urandom_range(1, 255));
			if ($urandom_range(1)) begin
				reg_write(REG_INFINITE, 1);
			end else begin
				reg_write(REG_INFINITE, 0);
				reg_write(REG_FLASH_COUNT, $urandom_range(100, 127));
			end
			return;
		end
		if ($urandom_range(99) < 60)
			reg_write(REG_START_COLOR, pick_color());
		if ($urandom_range(99) < 60)
			reg_write(REG_END_COLOR, pick_color());
		if ($urandom_range(99) < 40) begin
			r = $urandom_range(99);
			reg_write(REG_BRIGHTNESS, r < 15 ? 0 : r < 30 ? 255 : $urandom_range(1, 255));
		end
		if ($urandom_range(99) < 50) begin
			r = $urandom_range(99);
			reg_write(REG_FLASH_COUNT, r < 5 ? 0 : r < 10 ? 127 : $urandom_range(1, 6));
		end
		if ($urandom_range(99) < 60) begin
			r = $urandom_range(99);
			reg_write(REG_STEPS, r < 5 ? 0 : r < 10 ? $urandom_range(490, 511) :
				r < 25 ? $urandom_range(17, 64) : $urandom_range(1, 16));
		end
		if ($urandom_range(99) < 25)
			reg_write(REG_INFINITE, $urandom_range(1));
		if ($urandom_range(99) < 40)
			reg_write(REG_NEXT_MODE, $urandom_range(1));
	endtask

	initial begin
		int  sent;
		int  run_len;
		bit  marathon;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_tick(1);
		send_tick(0);
		send_tick(0);
		wait_idle();
		reg_write(REG_START_COLOR, 24'h00FF80);
		reg_write(REG_END_COLOR, 24'hFF0010);
		reg_write(REG_BRIGHTNESS, 255);
		reg_write(REG_FLASH_COUNT, 1);
		reg_write(REG_STEPS, 3);
		reg_write(REG_INFINITE, 0);
		reg_write(REG_NEXT_MODE, 1);
		reg_write(UNMAPPED_REG, '1);
		send_tick(1);
		repeat (7) send_tick(0);
		wait_idle();
		reg_write(REG_BRIGHTNESS, 0);
		send_tick(1);
		send_tick(0);
		wait_idle();
		reg_write(REG_BRIGHTNESS, 255);
		reg_write(REG_STEPS, 0);
		send_tick(1);
		send_tick(0);
		wait_idle();
		reg_write(REG_STEPS, 511);
		reg_write(REG_START_COLOR, 24'hFFFFFF);
		reg_write(REG_END_COLOR, 24'h000000);
		send_tick(1);
		send_tick(0);
		wait_idle();
		reg_write(REG_STEPS, 2);
		send_tick(0);
		wait_idle();
		reg_write(REG_FLASH_COUNT, 0);
		send_tick(0);
		wait_idle();
		reg_write(REG_INFINITE, 1);
		reg_write(REG_INFINITE, 1);
		repeat (3) send_tick(0);

		sent = 0;
		while (sent < RAND_TICKS) begin
			wait_idle();
			marathon = $urandom_range(7) == 0;
			shuffle_setup(marathon);
			gap_pct = $urandom_range(2) * 20;
			run_len = marathon ? $urandom_range(260, 320) : $urandom_range(20, 100);
			for (int i = 0; i < run_len && sent < RAND_TICKS; i++) begin
				quiet = sent >= RAND_TICKS - QUIET_TICKS;
				if (marathon)
					send_tick(i == 0);
				else
					send_tick(i == 0 ? 1'($urandom) : $urandom_range(99) < 4);
				sent++;
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
			$display("rgb_crossfade_flash_sequencer test passed");
		end else begin
			$display("rgb_crossfade_flash_sequencer test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/rcf_pkg.sv
design/rcf_regs.sv
design/rcf_ctrl.sv
design/rcf_dp.sv
design/rgb_crossfade_flash_sequencer.sv
tb/sv/tb.sv
